### design/cpi_pkg.sv
// Package of the cascaded PI buck regulator: payload structs, register
// indexes, sequencer states and fixed widths. Depends on nothing.
package cpi_pkg;

    localparam int GAIN_W  = 24;
    localparam int VAL_W   = 24;
    localparam int ERR_W   = 25;
    localparam int MAG_W   = 51;
    localparam int PROD_W  = 52;
    localparam int TERM_W  = 53;
    localparam int DUTY_W  = 16;
    localparam int IDX_W   = 3;
    localparam logic [MAG_W-1:0] PROD_LIMIT = MAG_W'(64'd1 << 50);
    localparam logic signed [ERR_W-1:0] ONE_VOLT = ERR_W'(256);

    typedef struct packed {
        logic signed [VAL_W-1:0] voltage_target;
        logic signed [VAL_W-1:0] voltage_measured;
        logic signed [VAL_W-1:0] current_measured;
    } t_sample;

    typedef struct packed {
        logic [DUTY_W-1:0]       duty_fraction;
        logic signed [VAL_W-1:0] current_reference;
    } t_result;

    typedef enum logic [IDX_W-1:0] {
        REG_VOLT_PROP_GAIN = 3'd0,
        REG_VOLT_INT_GAIN  = 3'd1,
        REG_CUR_PROP_GAIN  = 3'd2,
        REG_CUR_INT_GAIN   = 3'd3,
        REG_CUR_REF_MAX    = 3'd4,
        REG_CUR_REF_MIN    = 3'd5,
        REG_VOLT_CMD_MAX   = 3'd6,
        REG_VOLT_CMD_MIN   = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_MUL_P,
        ST_MUL_I,
        ST_CLAMP,
        ST_DIV,
        ST_SEND
    } t_state;

endpackage

### design/cpi_if.sv
// Request channel interfaces of the regulator: one for samples, one for results.
// Depends on cpi_pkg.
interface cpi_sample_if import cpi_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cpi_result_if import cpi_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/cpi_mul.sv
// Bit-serial saturating multiplier: one gain bit per cycle, MSB first.
// The product is capped at 2^50. Depends on cpi_pkg.
module cpi_mul import cpi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MAG_W-1:0]  i_mag,
    input  logic [GAIN_W-1:0] i_gain,
    output logic              o_done,
    output logic [MAG_W-1:0]  o_prod
);
    logic [MAG_W-1:0]  r_mag;
    logic [GAIN_W-1:0] r_gain, n_gain;
    logic [PROD_W-1:0] r_p, n_p;
    logic [4:0]        r_cnt, n_cnt;
    logic              r_done, n_done;

    always_comb begin
        n_p = {r_p[PROD_W-2:0], 1'b0} + (r_gain[GAIN_W-1] ? PROD_W'(r_mag) : '0);
        if (n_p > PROD_W'(PROD_LIMIT)) begin
            n_p = PROD_W'(PROD_LIMIT);
        end
        n_gain = {r_gain[GAIN_W-2:0], 1'b0};
        n_cnt  = r_cnt - 5'd1;
        n_done = (r_cnt == 5'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= 5'(GAIN_W);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt != '0) && n_done;
            if (r_cnt != '0) begin
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag  <= i_mag;
            r_gain <= i_gain;
            r_p    <= '0;
        end else if (r_cnt != '0) begin
            r_gain <= n_gain;
            r_p    <= n_p;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p[MAG_W-1:0];

endmodule

### design/cascaded_pi_buck_regulator.sv
// Top level of the cascaded voltage/current PI regulator for a buck stage.
// Depends on cpi_pkg, cpi_if (cpi_sample_if, cpi_result_if) and cpi_mul.
//
//   channel    direction  contents
//   i_sample   in         voltage_target, voltage_measured, current_measured
//   o_result   out        duty_fraction, current_reference
//   i_cfg_*    in         register index and write data, write only
//
// A sample goes from acceptance to a valid result through, per loop, an
// accumulate step, two passes of the shared bit-serial multiplier and a clamp
// step, then the restoring duty divider (skipped when the duty is zero or
// saturates) and a step that loads the result. The multiplier, one gain bit
// per cycle, takes most of that time. A new sample is accepted only once the
// sequencer is back in idle, after the previous result has been loaded.
// Reset is synchronous and active low; it restores the register defaults and
// clears both integrators. A result waits in the output register while the
// sink stalls; a new sample is taken as soon as the sequencer is idle.
module cascaded_pi_buck_regulator import cpi_pkg::*; #(
    parameter int INTEGRATOR_WIDTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    cpi_sample_if.sink               i_sample,
    cpi_result_if.source             o_result,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_idx,
    input  logic [GAIN_W-1:0]        i_cfg_data
);
    localparam int IW  = INTEGRATOR_WIDTH;
    localparam int XW  = 65;

    // Configuration registers.
    logic [GAIN_W-1:0]       r_vkp, r_vki, r_ikp, r_iki;
    logic signed [VAL_W-1:0] r_irmax, r_irmin, r_vcmin;
    logic [VAL_W-2:0]        r_vcmax;

    // Sequencer and datapath registers.
    t_state                  r_state, n_state;
    logic                    r_outer;
    t_sample                 r_smp;
    logic signed [ERR_W-1:0] r_err;
    logic signed [IW-1:0]    r_vsum, r_isum;
    logic signed [TERM_W-1:0] r_t;
    logic signed [VAL_W-1:0] r_iref;
    logic [VAL_W-1:0]        r_rem;
    logic [DUTY_W-1:0]       r_quo;
    logic [4:0]              r_dcnt;
    logic                    r_neg;
    logic                    r_ovalid;
    t_result                 r_out;

    // Combinational signals.
    logic                    w_accept, w_ostall;
    logic signed [ERR_W-1:0] w_err;
    logic signed [IW-1:0]    w_sum_old, w_sum_new;
    logic signed [IW:0]      w_sum_wide;
    logic                    w_mul_start, w_mul_done;
    logic [MAG_W-1:0]        w_mul_mag, w_mul_prod;
    logic [GAIN_W-1:0]       w_mul_gain;
    logic signed [XW-1:0]    w_opnd;
    logic [XW-1:0]           w_abs;
    logic                    w_opnd_neg;
    logic signed [TERM_W-1:0] w_sprod;
    logic signed [TERM_W-17:0] w_r, w_mx, w_mn, w_res;
    logic [VAL_W-1:0]        w_shift;

    assign w_accept = i_sample.valid && i_sample.ready;
    assign w_ostall = r_ovalid && !o_result.ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vkp   <= GAIN_W'(65536);
            r_vki   <= '0;
            r_ikp   <= GAIN_W'(65536);
            r_iki   <= '0;
            r_irmax <= VAL_W'(2560);
            r_irmin <= '0;
            r_vcmax <= (VAL_W-1)'(102400);
            r_vcmin <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_VOLT_PROP_GAIN: r_vkp   <= i_cfg_data;
                REG_VOLT_INT_GAIN:  r_vki   <= i_cfg_data;
                REG_CUR_PROP_GAIN:  r_ikp   <= i_cfg_data;
                REG_CUR_INT_GAIN:   r_iki   <= i_cfg_data;
                REG_CUR_REF_MAX:    r_irmax <= i_cfg_data;
                REG_CUR_REF_MIN:    r_irmin <= i_cfg_data;
                REG_VOLT_CMD_MAX:   r_vcmax <= i_cfg_data[VAL_W-2:0];
                REG_VOLT_CMD_MIN:   r_vcmin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Loop error and the saturating integrator update of the active loop.
    always_comb begin
        if (r_outer) begin
            w_err     = ERR_W'(r_smp.voltage_target) - ERR_W'(r_smp.voltage_measured);
            w_sum_old = r_vsum;
        end else begin
            w_err     = ERR_W'(r_iref) - ERR_W'(r_smp.current_measured);
            w_sum_old = r_isum;
        end
        w_sum_wide = (IW+1)'(w_sum_old) + (IW+1)'(w_err);
        if (w_sum_wide[IW] != w_sum_wide[IW-1]) begin
            w_sum_new = w_sum_wide[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        end else begin
            w_sum_new = w_sum_wide[IW-1:0];
        end
    end

    // Multiplier operand: the error in the accumulate cycle, the fresh
    // integrator when the proportional product completes. Magnitudes above
    // the product limit saturate anyway, so they are capped here.
    always_comb begin
        if (r_state == ST_ACC) begin
            w_opnd     = XW'(w_err);
            w_mul_gain = r_outer ? r_vkp : r_ikp;
        end else begin
            w_opnd     = XW'(r_outer ? r_vsum : r_isum);
            w_mul_gain = r_outer ? r_vki : r_iki;
        end
        w_opnd_neg = w_opnd[XW-1];
        w_abs      = w_opnd_neg ? XW'(-w_opnd) : XW'(w_opnd);
        w_mul_mag  = (w_abs > XW'(PROD_LIMIT)) ? PROD_LIMIT : w_abs[MAG_W-1:0];
        w_sprod    = r_neg ? -TERM_W'({1'b0, w_mul_prod}) : TERM_W'({1'b0, w_mul_prod});
    end

    // Floor shift of the loop sum to Q16.8, then the max-first clamp.
    always_comb begin
        w_r = r_t[TERM_W-1:16];
        if (r_outer) begin
            w_mx = (TERM_W-16)'(r_irmax);
            w_mn = (TERM_W-16)'(r_irmin);
        end else begin
            w_mx = (TERM_W-16)'({1'b0, r_vcmax});
            w_mn = (TERM_W-16)'(r_vcmin);
        end
        if (w_r > w_mx) begin
            w_res = w_mx;
        end else if (w_r < w_mn) begin
            w_res = w_mn;
        end else begin
            w_res = w_r;
        end
        w_shift = {r_rem[VAL_W-2:0], 1'b0};
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_ACC;
            ST_ACC:   n_state = ST_MUL_P;
            ST_MUL_P: if (w_mul_done) n_state = ST_MUL_I;
            ST_MUL_I: if (w_mul_done) n_state = ST_CLAMP;
            ST_CLAMP: begin
                if (r_outer) begin
                    n_state = ST_ACC;
                end else if (w_res <= 0 || w_res[VAL_W-2:0] >= r_vcmax) begin
                    n_state = ST_SEND;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV:   if (r_dcnt == 5'd1) n_state = ST_SEND;
            ST_SEND:  if (!w_ostall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Handshake and unit control.
    always_comb begin
        i_sample.ready = (r_state == ST_IDLE);
        w_mul_start    = (r_state == ST_ACC) || (r_state == ST_MUL_P && w_mul_done);
        o_result.valid = r_ovalid;
        o_result.data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_outer  <= 1'b0;
            r_vsum   <= '0;
            r_isum   <= '0;
            r_ovalid <= 1'b0;
            r_dcnt   <= '0;
        end else begin
            r_state <= n_state;
            // A new result replaces the one leaving on this edge, if any.
            if (r_state == ST_SEND && !w_ostall) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_result.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_outer <= 1'b1;
                    end
                end
                ST_ACC: begin
                    if (r_outer) begin
                        r_vsum <= w_sum_new;
                    end else begin
                        r_isum <= w_sum_new;
                    end
                end
                ST_CLAMP: begin
                    if (r_outer) begin
                        // The outer integral restarts whenever the voltage
                        // error is below one volt.
                        if (r_err < ONE_VOLT) begin
                            r_vsum <= '0;
                        end
                        r_outer <= 1'b0;
                    end
                    r_dcnt <= 5'(DUTY_W);
                end
                ST_DIV: begin
                    r_dcnt <= r_dcnt - 5'd1;
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_smp <= i_sample.data;
        end
        if (r_state == ST_ACC) begin
            r_err <= w_err;
            r_t   <= '0;
        end
        if (w_mul_start) begin
            r_neg <= w_opnd_neg;
        end
        if ((r_state == ST_MUL_P || r_state == ST_MUL_I) && w_mul_done) begin
            r_t <= r_t + w_sprod;
        end
        if (r_state == ST_CLAMP) begin
            if (r_outer) begin
                r_iref <= w_res[VAL_W-1:0];
            end else begin
                r_rem <= w_res[VAL_W-1:0];
                if (w_res <= 0) begin
                    r_quo <= '0;
                end else begin
                    r_quo <= '1;
                end
            end
        end
        if (r_state == ST_DIV) begin
            if (w_shift >= {1'b0, r_vcmax}) begin
                r_rem <= w_shift - {1'b0, r_vcmax};
                r_quo <= {r_quo[DUTY_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[DUTY_W-2:0], 1'b0};
            end
        end
        if (r_state == ST_SEND && !w_ostall) begin
            r_out.duty_fraction     <= r_quo;
            r_out.current_reference <= r_iref;
        end
    end

    cpi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_mag   (w_mul_mag),
        .i_gain  (w_mul_gain),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

`ifndef NO_ASSERTIONS
    a_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == ST_MUL_P || r_state == ST_MUL_I))
        else $error("multiplier finished outside a multiply state");
    a_vsum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLAMP && r_outer && r_err < ONE_VOLT) |=> (r_vsum == '0))
        else $error("voltage integral not cleared on small error");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_dcnt != '0 && r_dcnt <= 5'(DUTY_W)))
        else $error("divider step count out of range");
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == ST_SEND))
        else $error("result raised outside the send step");
`endif

endmodule

### sim/testbench.sv
// Self-checking testbench for the cascaded PI buck regulator.
// Depends on cpi_pkg, the cpi_if interfaces and the regulator top level.
`timescale 1ns / 100ps

module testbench import cpi_pkg::*; ();

    localparam int  RST_CYCLES  = 11;
    localparam int  DRAIN_WAIT  = 250;     // settle time after the last owed result
    localparam int  HOLD_CYCLES = 3000;
    localparam int  ITEMS_PER_PHASE = 90;
    localparam int  PHASES      = 10;
    localparam longint CYCLE_LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [IDX_W-1:0]  i_cfg_idx;
    logic [GAIN_W-1:0] i_cfg_data;

    cpi_sample_if smp ();
    cpi_result_if res ();

    cascaded_pi_buck_regulator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp),
        .o_result   (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the configuration and of both integrators.
    longint kp_v, ki_v, kp_i, ki_i;
    longint iref_hi, iref_lo, cmd_hi, cmd_lo;
    longint vsum, isum;

    t_result pending[$];      // results the regulator still owes us
    int      errors;
    bit      calm;            // when set neither side idles
    int      hold_seq;        // bumped by the stimulus to ask for a long sink stall
    longint  cycles;

    // One row of the directed table. Rows with check set carry a result that
    // can be read straight off the arithmetic; the rest go through the predictor.
    typedef struct {
        logic [VAL_W-1:0]  vt, vm, im;
        bit                check;
        logic [DUTY_W-1:0] duty;
        logic [VAL_W-1:0]  iref;
    } t_row;
    t_row rows[$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run-away guard.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic longint sext24(logic [23:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic void load_defaults();
        kp_v = 65536; ki_v = 0; kp_i = 65536; ki_i = 0;
        iref_hi = 2560; iref_lo = 0; cmd_hi = 102400; cmd_lo = 0;
        vsum = 0; isum = 0;
    endfunction

    function automatic void shadow_write(t_reg_idx idx, logic [GAIN_W-1:0] v);
        case (idx)
            REG_VOLT_PROP_GAIN: kp_v = longint'(v);
            REG_VOLT_INT_GAIN:  ki_v = longint'(v);
            REG_CUR_PROP_GAIN:  kp_i = longint'(v);
            REG_CUR_INT_GAIN:   ki_i = longint'(v);
            REG_CUR_REF_MAX:    iref_hi = sext24(v);
            REG_CUR_REF_MIN:    iref_lo = sext24(v);
            REG_VOLT_CMD_MAX:   cmd_hi = longint'(v[22:0]);
            REG_VOLT_CMD_MIN:   cmd_lo = sext24(v);
            default: ;
        endcase
    endfunction

    // Integrator add, saturating to the signed 40-bit range.
    function automatic longint integrate(longint sum, longint e);
        longint hi;
        longint lo;
        longint r;
        hi = (longint'(1) <<< 39) - 1;
        lo = -hi - 1;
        r = sum + e;
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return r;
    endfunction

    // Gain product with its magnitude held to 2^50.
    function automatic longint gain_product(longint s, longint g);
        longint unsigned mag;
        bit [127:0] p;
        mag = (s < 0) ? longint'(-s) : longint'(s);
        p = 128'(mag) * 128'(g);
        if (p > (128'd1 << 50)) p = 128'd1 << 50;
        return (s < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    // One PI loop: Q.24 sum of both terms, floored back to Q16.8, then clamped.
    function automatic longint pi_loop(longint e, longint kp, longint sum, longint ki,
                                       longint mx, longint mn);
        longint r;
        r = (gain_product(e, kp) + gain_product(sum, ki)) >>> 16;
        if (r > mx) r = mx;
        else if (r < mn) r = mn;
        return r;
    endfunction

    // Works out the result of one sample and advances the shadow integrators.
    function automatic t_result regulate(t_sample s);
        longint ve, iref, ie, cmd, duty;
        t_result r;
        ve = sext24(s.voltage_target) - sext24(s.voltage_measured);
        vsum = integrate(vsum, ve);
        iref = pi_loop(ve, kp_v, vsum, ki_v, iref_hi, iref_lo);
        // The voltage integral is dropped whenever the error is under one volt.
        if (ve < 256) vsum = 0;
        ie = iref - sext24(s.current_measured);
        isum = integrate(isum, ie);
        cmd = pi_loop(ie, kp_i, isum, ki_i, cmd_hi, cmd_lo);
        if (cmd <= 0) duty = 0;
        else if (cmd_hi == 0) duty = 65535;
        else begin
            duty = (cmd <<< 16) / cmd_hi;
            if (duty > 65535) duty = 65535;
        end
        r.duty_fraction = duty[15:0];
        r.current_reference = iref[23:0];
        return r;
    endfunction

    // Writes a set of registers on back-to-back edges; the regulator is idle here.
    task automatic write_regs(input logic [GAIN_W-1:0] vals[8]);
        for (int k = 0; k < 8; k++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= k[IDX_W-1:0];
            i_cfg_data <= vals[k];
            shadow_write(t_reg_idx'(k), vals[k]);
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every owed result has come back, then lets the pipeline settle.
    task automatic drain();
        while (pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Offers one sample, after random idle cycles unless calm is set, and books
    // the expected result on the edge where the request is taken.
    task automatic send(input t_sample s, input bit typed, input t_result want);
        t_result got;
        if (!calm) begin
            while ($urandom_range(99) < 37) begin
                @(posedge i_clk);
                smp.valid <= 1'b0;
            end
        end
        @(posedge i_clk);
        smp.valid <= 1'b1;
        smp.data  <= s;
        do @(posedge i_clk); while (!smp.ready);
        got = regulate(s);
        pending.push_back(typed ? want : got);
        // The request is taken on this edge, so it is withdrawn here.
        smp.valid <= 1'b0;
    endtask

    task automatic idle_valid();
        @(posedge i_clk);
        smp.valid <= 1'b0;
    endtask

    function automatic void add_row(logic [23:0] vt, logic [23:0] vm, logic [23:0] im,
                                    bit check, logic [15:0] duty, logic [23:0] iref);
        t_row r;
        r.vt = vt; r.vm = vm; r.im = im;
        r.check = check; r.duty = duty; r.iref = iref;
        rows.push_back(r);
    endfunction

    function automatic logic [23:0] gain_pick();
        case ($urandom_range(3))
            0: return 24'($urandom_range(0, 1 << 16));
            1: return 24'($urandom_range(0, 1 << 20));
            2: return 24'($urandom_range(0, 1 << 12));
            default: return 24'($urandom);
        endcase
    endfunction

    // Settings for one random phase; a few phases pin the extremes.
    task automatic pick_setting(input int phase, output logic [GAIN_W-1:0] v[8]);
        int a, b;
        for (int k = 0; k < 4; k++) v[k] = gain_pick();
        a = $urandom_range(0, 8000);
        b = $urandom_range(0, 8000);
        v[REG_CUR_REF_MAX]  = 24'(a);
        v[REG_CUR_REF_MIN]  = 24'(-b);
        v[REG_VOLT_CMD_MAX] = 24'($urandom_range(1, 200000));
        v[REG_VOLT_CMD_MIN] = 24'(-$urandom_range(0, 20000));
        case (phase)
            0: begin
                for (int k = 0; k < 4; k++) v[k] = 24'hFFFFFF;
                v[REG_CUR_REF_MAX]  = 24'h7FFFFF;
                v[REG_CUR_REF_MIN]  = 24'h800000;
                v[REG_VOLT_CMD_MAX] = 24'h7FFFFF;
                v[REG_VOLT_CMD_MIN] = 24'h800000;
            end
            1: begin
                for (int k = 0; k < 4; k++) v[k] = 24'h000000;
                v[REG_VOLT_CMD_MAX] = 24'h000001;
            end
            2: begin
                // Crossed limits: min above max on both clamps.
                v[REG_CUR_REF_MAX]  = 24'(-a);
                v[REG_CUR_REF_MIN]  = 24'(b + 1);
                v[REG_VOLT_CMD_MAX] = 24'(1000);
                v[REG_VOLT_CMD_MIN] = 24'(5000);
            end
            3: begin
                // Only bit 23 set, so the 23-bit divisor lands on zero.
                v[REG_VOLT_CMD_MAX] = 24'h800000;
            end
            default: ;
        endcase
    endtask

    function automatic t_sample random_sample();
        t_sample s;
        int base;
        if ($urandom_range(99) < 70) begin
            // Near regulation: small voltage errors on either side of one volt.
            base = $urandom_range(0, 12000);
            s.voltage_target   = 24'(base);
            s.voltage_measured = 24'(base + $urandom_range(0, 1400) - 700);
            s.current_measured = 24'($urandom_range(0, 10000) - 5000);
        end else begin
            s.voltage_target   = 24'($urandom);
            s.voltage_measured = 24'($urandom);
            s.current_measured = 24'($urandom);
        end
        return s;
    endfunction

    // Result side: random stalls, one long hold-off on request, and the check
    // of every taken result against the oldest expectation.
    initial begin
        int seen;
        int hold_left;
        t_result want;
        seen = 0;
        hold_left = 0;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res.valid && res.ready) begin
                if (pending.size() == 0) begin
                    $display("%0t: result with nothing expected, got duty %0d iref %0d",
                             $time, res.data.duty_fraction,
                             res.data.current_reference);
                    errors++;
                end else begin
                    want = pending.pop_front();
                    if (res.data.duty_fraction !== want.duty_fraction) begin
                        $display("%0t: duty_fraction expected %0d got %0d", $time,
                                 want.duty_fraction, res.data.duty_fraction);
                        errors++;
                    end
                    if (res.data.current_reference !== want.current_reference) begin
                        $display("%0t: current_reference expected %0d got %0d", $time,
                                 want.current_reference, res.data.current_reference);
                        errors++;
                    end
                end
            end
            if (hold_seq != seen) begin
                seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else begin
                res.ready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
            end
        end
    end

    // Main stimulus: reset, the directed table on defaults, an integral-gain run,
    // then random phases split by full drains so registers change only when idle.
    initial begin
        logic [GAIN_W-1:0] setting[8];
        t_sample s;
        t_result want;
        errors = 0;
        calm = 1'b0;
        hold_seq = 0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        smp.valid  <= 1'b0;
        smp.data   <= '0;
        load_defaults();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows. With integral gains at zero and unit proportional gains,
        // the first rows follow straight from the default limits.
        add_row(24'h000000, 24'h000000, 24'h000000, 1, 16'd0,     24'd0);
        add_row(24'h7FFFFF, 24'h800000, 24'h000000, 1, 16'd1638,  24'd2560);
        add_row(24'h800000, 24'h7FFFFF, 24'h000000, 1, 16'd0,     24'd0);
        add_row(24'h000000, 24'h000000, 24'h800000, 1, 16'd65535, 24'd0);
        add_row(24'h000000, 24'h000000, 24'h7FFFFF, 0, 0, 0);
        add_row(24'h000100, 24'h000000, 24'h000000, 0, 0, 0);   // exactly one volt
        add_row(24'h0000FF, 24'h000000, 24'h000000, 0, 0, 0);   // just under one volt
        add_row(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0, 0, 0);
        add_row(24'h800000, 24'h800000, 24'h800000, 0, 0, 0);
        add_row(24'h555555, 24'hAAAAAA, 24'h5A5A5A, 0, 0, 0);
        add_row(24'hAAAAAA, 24'h555555, 24'hA5A5A5, 0, 0, 0);
        add_row(24'h000C00, 24'h000A00, 24'hFFF000, 0, 0, 0);
        foreach (rows[k]) begin
            s.voltage_target   = rows[k].vt;
            s.voltage_measured = rows[k].vm;
            s.current_measured = rows[k].im;
            want.duty_fraction     = rows[k].duty;
            want.current_reference = rows[k].iref;
            send(s, rows[k].check, want);
        end
        idle_valid();
        drain();

        // Integral gains on, so the integrators matter.
        setting = '{24'h010000, 24'h008000, 24'h020000, 24'h004000,
                    24'd2560, 24'h000000, 24'd102400, 24'h000000};
        write_regs(setting);
        for (int k = 0; k < 10; k++) begin
            s.voltage_target   = (k % 2) ? 24'h7FFFFF : 24'h000400;
            s.voltage_measured = (k % 2) ? 24'h800000 : 24'h000000;
            s.current_measured = 24'h800000;
            send(s, 0, want);
        end
        idle_valid();
        drain();

        for (int p = 0; p < PHASES; p++) begin
            pick_setting(p, setting);
            write_regs(setting);
            calm = (p == 6);
            // The sink holds off for a long stretch while samples keep coming.
            if (p == 4) hold_seq++;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) send(random_sample(), 0, want);
            idle_valid();
            // The sender pauses here until every result is back.
            drain();
        end
        calm = 1'b0;

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
